[src/work_block_partitioner_assert.svh]
// Assertion macros shared by the work block partitioner modules.
`ifndef WORK_BLOCK_PARTITIONER_ASSERT_SVH
`define WORK_BLOCK_PARTITIONER_ASSERT_SVH

`ifndef SYNTHESIS
`define WBP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wbp assertion failed: ante |-> cons");
`define WBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wbp assertion failed: ante |=> cons");
`else
`define WBP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WBP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/wbp_pkg.sv]
// Shared widths, constants, register indexes and divider interface types.
package wbp_pkg;

   localparam int WORK_W = 24;
   localparam int NP_W = 9;
   localparam int MB_W = 11;
   localparam int NB_W = WORK_W + 1;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 11;
   localparam int PROC_GROUP = 16;

   localparam logic [NP_W-1:0] NP_RESET = NP_W'(16);
   localparam logic [MB_W-1:0] MB_RESET = MB_W'(256);
   localparam logic [NB_W-1:0] NB_INIT = NB_W'(2 * PROC_GROUP);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_PROCESSORS = 1'b0,
      CSR_MAX_BLOCK_SIZE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              start;
      logic [WORK_W-1:0] dividend;
      logic [NB_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORK_W-1:0] quotient;
      logic [WORK_W-1:0] remainder;
   } div_rsp_type;

endpackage

[src/work_block_partitioner.sv]
// Work block partitioner: sequencer around one shared serial divider.
// Small load: divide by num_processors, then (if nonzero) by items per block. Large load: up
// to 19 scaling steps, divide by max_block_size, divide by block count, then on a remainder
// block up to 18 block-count doublings, each divided anew. One request at a time; the next is
// taken as the result appears. A result waiting on rsp_ready holds the block in its last step.
// Synchronous active-high reset: num_processors 16, max_block_size 256, no result held.
`include "work_block_partitioner_assert.svh"

module work_block_partitioner (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wbp_pkg::WORK_W-1:0]        req_work_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [wbp_pkg::WORK_W-1:0]        rsp_block_count,
   output logic [wbp_pkg::MB_W-1:0]          rsp_items_per_block,
   output logic [wbp_pkg::MB_W-1:0]          rsp_items_last_block,
   output logic                              rsp_valid_res,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wbp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wbp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int W = wbp_pkg::WORK_W;
   localparam int NPW = wbp_pkg::NP_W;
   localparam int MBW = wbp_pkg::MB_W;
   localparam int NBW = wbp_pkg::NB_W;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_SCALE   = 8'b0000_0010,
      S_DIV_NP  = 8'b0000_0100,
      S_DIV_IPB = 8'b0000_1000,
      S_DIV_MB  = 8'b0001_0000,
      S_DIV_NB  = 8'b0010_0000,
      S_CHECK   = 8'b0100_0000,
      S_FINISH  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [NPW-1:0]    np_ff, np_in;
   logic [MBW-1:0]    mb_ff, mb_in;
   logic              pend_ff, pend_in;
   logic [W-1:0]      cnt_ff, cnt_in;
   logic [NBW-1:0]    m_ff, m_in;
   logic [NBW-1:0]    nb_ff, nb_in;
   logic [MBW-1:0]    ipb_ff, ipb_in;
   logic [W-1:0]      rem_ff, rem_in;
   logic              keep_ff, keep_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]      rsp_nb_ff, rsp_nb_in;
   logic [MBW-1:0]    rsp_ipb_ff, rsp_ipb_in;
   logic [MBW-1:0]    rsp_lb_ff, rsp_lb_in;
   logic              rsp_ok_ff, rsp_ok_in;

   logic [NPW-1:0]    np_eff;
   logic [MBW-1:0]    mb_eff;
   logic [MBW+NPW-1:0] small_lim;
   logic [NBW-1:0]    m_init;
   logic [W:0]        ceil_sum;
   logic [NBW:0]      nb_dbl;
   logic [W-1:0]      lb_out;
   logic              ok;

   wbp_pkg::div_req_type div_req;
   wbp_pkg::div_rsp_type div_rsp;

   wbp_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      np_in = np_ff;
      mb_in = mb_ff;
      if (csr_valid) begin
         unique case (wbp_pkg::csr_index_type'(csr_index))
            wbp_pkg::CSR_NUM_PROCESSORS: np_in = csr_wdata[NPW-1:0];
            wbp_pkg::CSR_MAX_BLOCK_SIZE: mb_in = csr_wdata[MBW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      np_eff = (np_ff == '0) ? NPW'(1) : np_ff;
      mb_eff = (mb_ff == '0) ? MBW'(1) : mb_ff;
      small_lim = (MBW + NPW)'(mb_eff) * (MBW + NPW)'(np_eff);
      m_init = (NBW'(mb_eff) * NBW'(wbp_pkg::PROC_GROUP)) << 1;
      ceil_sum = {1'b0, div_rsp.quotient} + (W + 1)'(div_rsp.remainder != '0);
      nb_dbl = {nb_ff, 1'b0};
      lb_out = keep_ff ? rem_ff : '0;
      ok = (keep_ff || (rem_ff == '0)) && (lb_out <= W'(mb_eff)) && (ipb_ff <= mb_eff);

      state_in = state_ff;
      pend_in = pend_ff;
      cnt_in = cnt_ff;
      m_in = m_ff;
      nb_in = nb_ff;
      ipb_in = ipb_ff;
      rem_in = rem_ff;
      keep_in = keep_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_nb_in = rsp_nb_ff;
      rsp_ipb_in = rsp_ipb_ff;
      rsp_lb_in = rsp_lb_ff;
      rsp_ok_in = rsp_ok_ff;

      div_req.start = 1'b0;
      div_req.dividend = cnt_ff;
      div_req.divisor = nb_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cnt_in = req_work_count;
               m_in = m_init;
               nb_in = wbp_pkg::NB_INIT;
               keep_in = 1'b1;
               if (req_work_count <= W'(small_lim)) begin
                  state_in = S_DIV_NP;
               end else begin
                  state_in = S_SCALE;
               end
            end
         end
         S_SCALE: begin
            // double the group count until it covers the load
            if (m_ff < NBW'(cnt_ff)) begin
               m_in = m_ff << 1;
               nb_in = nb_ff << 1;
            end else begin
               state_in = S_DIV_MB;
            end
         end
         S_DIV_NP: begin
            div_req.divisor = NBW'(np_eff);
            div_req.start = !pend_ff;
            if (div_rsp.done) begin
               ipb_in = ceil_sum[MBW-1:0];
               if (ceil_sum == '0) begin
                  nb_in = '0;
                  rem_in = '0;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_DIV_IPB;
               end
            end
         end
         S_DIV_IPB: begin
            div_req.divisor = NBW'(ipb_ff);
            div_req.start = !pend_ff;
            if (div_rsp.done) begin
               nb_in = NBW'(div_rsp.quotient);
               rem_in = div_rsp.remainder;
               state_in = S_FINISH;
            end
         end
         S_DIV_MB: begin
            div_req.divisor = NBW'(mb_eff);
            div_req.start = !pend_ff;
            if (div_rsp.done) begin
               keep_in = (div_rsp.remainder != '0);
               state_in = S_DIV_NB;
            end
         end
         S_DIV_NB: begin
            div_req.divisor = nb_ff;
            div_req.start = !pend_ff;
            if (div_rsp.done) begin
               ipb_in = div_rsp.quotient[MBW-1:0];
               rem_in = div_rsp.remainder;
               state_in = keep_ff ? S_CHECK : S_FINISH;
            end
         end
         S_CHECK: begin
            // remainder too big: double the block count unless blocks would empty
            if (rem_ff > W'(mb_eff)) begin
               if ((NBW + 1)'(cnt_ff) < nb_dbl) begin
                  state_in = S_FINISH;
               end else begin
                  nb_in = nb_dbl[NBW-1:0];
                  state_in = S_DIV_NB;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_nb_in = nb_ff[W-1:0];
               rsp_ipb_in = ipb_ff;
               rsp_lb_in = lb_out[MBW-1:0];
               rsp_ok_in = ok;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (div_req.start) begin
         pend_in = 1'b1;
      end else if (div_rsp.done) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         np_ff <= wbp_pkg::NP_RESET;
         mb_ff <= wbp_pkg::MB_RESET;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         np_ff <= np_in;
         mb_ff <= mb_in;
      end
      cnt_ff <= cnt_in;
      m_ff <= m_in;
      nb_ff <= nb_in;
      ipb_ff <= ipb_in;
      rem_ff <= rem_in;
      keep_ff <= keep_in;
      rsp_nb_ff <= rsp_nb_in;
      rsp_ipb_ff <= rsp_ipb_in;
      rsp_lb_ff <= rsp_lb_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_block_count = rsp_nb_ff;
   assign rsp_items_per_block = rsp_ipb_ff;
   assign rsp_items_last_block = rsp_lb_ff;
   assign rsp_valid_res = rsp_ok_ff;

   `WBP_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != S_IDLE)
   // the four divide states hold one-hot bits 2 through 5
   `WBP_ASSERT_IMPL(a_done_in_div_state, clock, reset, div_rsp.done, |state_ff[5:2])
   `WBP_ASSERT_IMPL(a_result_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_FINISH))

endmodule

[src/wbp_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
`include "work_block_partitioner_assert.svh"

module wbp_divider (
   input  logic                clock,
   input  logic                reset,
   input  wbp_pkg::div_req_type div_req,
   output wbp_pkg::div_rsp_type div_rsp
);

   localparam int W = wbp_pkg::WORK_W;
   localparam int DW = wbp_pkg::NB_W;
   localparam int STEP_W = $clog2(W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [W-1:0]      quo_ff, quo_in;
   logic [W-1:0]      rem_ff, rem_in;
   logic [DW-1:0]     divisor_ff, divisor_in;

   logic [W:0]        trial;
   logic [W:0]        diff;
   logic              fits;

   always_comb begin
      trial = {rem_ff, quo_ff[W-1]};
      fits = ((W + 1)'(trial) >= (W + 1)'(divisor_ff));
      diff = trial - (W + 1)'(divisor_ff);

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(W);
         quo_in = div_req.dividend;
         rem_in = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         quo_in = {quo_ff[W-2:0], fits};
         rem_in = fits ? diff[W-1:0] : trial[W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;
   assign div_rsp.remainder = rem_ff;

   `WBP_ASSERT_IMPL(a_div_start_when_idle, clock, reset, div_req.start, !busy_ff)
   `WBP_ASSERT_IMPL(a_div_done_after_busy, clock, reset, done_ff, $past(busy_ff))
   `WBP_ASSERT_IMPL(a_div_busy_has_steps, clock, reset, busy_ff, step_ff != '0)

endmodule

[bench/work_block_partitioner_tb.sv]
// Self-checking regression bench for the work block partitioner.
module work_block_partitioner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORK_W = wbp_pkg::WORK_W;
   localparam int NP_W = wbp_pkg::NP_W;
   localparam int MB_W = wbp_pkg::MB_W;
   localparam int CSR_DATA_W = wbp_pkg::CSR_DATA_W;

   typedef struct {
      logic [WORK_W-1:0] work_count;
      logic [WORK_W-1:0] block_count;
      logic [MB_W-1:0]   items_per_block;
      logic [MB_W-1:0]   items_last_block;
      logic              fits;
   } split_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [WORK_W-1:0]     req_work_count = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WORK_W-1:0]     rsp_block_count;
   logic [MB_W-1:0]       rsp_items_per_block;
   logic [MB_W-1:0]       rsp_items_last_block;
   logic                  rsp_valid_res;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   wbp_pkg::csr_index_type csr_index = wbp_pkg::CSR_NUM_PROCESSORS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [NP_W-1:0] np_setting = wbp_pkg::NP_RESET;
   logic [MB_W-1:0] mb_setting = wbp_pkg::MB_RESET;
   split_type       expected_splits[$];
   int              mismatch_count = 0;
   int              send_idle_pct = 30;
   int              recv_idle_pct = 30;
   int              rsp_holdoff_cycles = 0;

   always #5 clock = ~clock;

   work_block_partitioner u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_work_count       (req_work_count),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_block_count      (rsp_block_count),
      .rsp_items_per_block  (rsp_items_per_block),
      .rsp_items_last_block (rsp_items_last_block),
      .rsp_valid_res        (rsp_valid_res),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   function automatic split_type predict_split(input logic [WORK_W-1:0] work_count);
      logic [63:0] cnt, procs, limit, group, scale, nb, ipb, lb;
      int          steps;
      split_type   s;
      cnt   = 64'(work_count);
      procs = (np_setting == 0) ? 64'd1 : 64'(np_setting);
      limit = (mb_setting == 0) ? 64'd1 : 64'(mb_setting);
      group = 64'(wbp_pkg::PROC_GROUP);
      lb    = 64'd0;
      if (cnt <= limit * procs) begin
         ipb = (cnt + procs - 1) / procs;
         nb  = (ipb != 0) ? cnt / ipb : 64'd0;
         if (cnt % procs != 0)
            lb = cnt - ipb * nb;
      end else begin
         scale = 64'd2;
         while (scale * limit * group < cnt)
            scale = scale * 2;
         nb  = scale * group;
         ipb = cnt / nb;
         if (cnt % limit != 0) begin
            lb    = cnt - ipb * nb;
            steps = 0;
            // double the block count until the remainder fits, unless blocks would go empty
            while (steps < 64 && lb > limit && cnt / (nb * 2) != 0) begin
               nb    = nb * 2;
               ipb   = cnt / nb;
               lb    = cnt - ipb * nb;
               steps = steps + 1;
            end
         end
      end
      s.work_count       = work_count;
      s.block_count      = nb[WORK_W-1:0];
      s.items_per_block  = ipb[MB_W-1:0];
      s.items_last_block = lb[MB_W-1:0];
      s.fits             = (nb * ipb + lb == cnt) && (lb <= limit) && (ipb <= limit);
      return s;
   endfunction

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return $urandom_range(1, 3);
      else if (roll < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic [WORK_W-1:0] work_count,
                                  input logic [WORK_W-1:0] got, input logic [WORK_W-1:0] want);
      $display("%0t mismatch %s for work_count %0d: got %0d expected %0d",
               $realtime, what, work_count, got, want);
      mismatch_count++;
   endtask

   // Check every accepted response against the oldest pending split.
   always @(posedge clock) begin
      split_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_splits.size() == 0) begin
            report_mismatch("response with no request pending", '0, rsp_block_count, '0);
         end else begin
            want = expected_splits.pop_front();
            if (rsp_block_count !== want.block_count)
               report_mismatch("block_count", want.work_count, rsp_block_count,
                               want.block_count);
            if (rsp_items_per_block !== want.items_per_block)
               report_mismatch("items_per_block", want.work_count,
                               WORK_W'(rsp_items_per_block), WORK_W'(want.items_per_block));
            if (rsp_items_last_block !== want.items_last_block)
               report_mismatch("items_last_block", want.work_count,
                               WORK_W'(rsp_items_last_block), WORK_W'(want.items_last_block));
            if (rsp_valid_res !== want.fits)
               report_mismatch("valid_res", want.work_count, WORK_W'(rsp_valid_res),
                               WORK_W'(want.fits));
         end
      end
   end

   // Response side: long hold-off on demand, otherwise random stalls.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_holdoff_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_holdoff_cycles = rsp_holdoff_cycles - 1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < recv_idle_pct)
               stall_left = pick_gap();
         end
      end
   end

   task automatic pause_sender();
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Offer one request; starts and ends at a falling edge.
   task automatic send_work(input logic [WORK_W-1:0] count);
      req_valid      <= 1'b1;
      req_work_count <= count;
      do @(posedge clock); while (!(req_valid && req_ready));
      expected_splits.push_back(predict_split(count));
      @(negedge clock);
      pause_sender();
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_splits.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input wbp_pkg::csr_index_type index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (index == wbp_pkg::CSR_NUM_PROCESSORS)
         np_setting = data[NP_W-1:0];
      else
         mb_setting = data[MB_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [WORK_W-1:0] pick_work_count();
      logic [63:0] procs, limit, span, value, mult;
      int unsigned roll;
      procs = (np_setting == 0) ? 64'd1 : 64'(np_setting);
      limit = (mb_setting == 0) ? 64'd1 : 64'(mb_setting);
      span  = limit * procs;
      roll  = $urandom_range(0, 99);
      mult  = limit * 64'($urandom_range(1, 32'(64'hFFFFFF / limit)));
      if (roll < 30)
         value = 64'($urandom_range(0, 32'(span)));
      else if (roll < 40)
         value = span + 64'($urandom_range(0, 2)) - 64'd1;
      else if (roll < 55)
         value = mult;
      else if (roll < 70)
         value = $urandom_range(0, 1) ? mult + 64'd1 : mult - 64'd1;
      else if (roll < 85)
         value = 64'($urandom);
      else
         value = 64'($urandom_range(0, 64));
      return value[WORK_W-1:0];
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_num_processors(input int phase);
      case (phase)
         0: return '0;
         1: return CSR_DATA_W'(1);
         2: return CSR_DATA_W'(256);
         3: return '1;
         default: return $urandom_range(0, 1) ? CSR_DATA_W'($urandom_range(1, 256))
                                               : CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_max_block(input int phase);
      int unsigned roll;
      roll = $urandom_range(0, 3);
      case (phase)
         0: return '0;
         1: return '1;
         2: return CSR_DATA_W'(1);
         3: return CSR_DATA_W'(1024);
         default: begin
            if (roll < 2)
               return CSR_DATA_W'($urandom_range(1, 1024));
            else if (roll == 2)
               return CSR_DATA_W'($urandom);
            return CSR_DATA_W'($urandom_range(1, 16));
         end
      endcase
   endfunction

   task automatic test_default_registers();
      logic [WORK_W-1:0] counts[11];
      counts = '{0, 1, 15, 16, 17, 4095, 4096, 4097, 8192, 8193, 24'hFFFFFF};
      foreach (counts[i])
         send_work(counts[i]);
      drain_results();
   endtask

   task automatic test_zero_registers();
      write_csr(wbp_pkg::CSR_NUM_PROCESSORS, '0);
      write_csr(wbp_pkg::CSR_MAX_BLOCK_SIZE, '0);
      send_work(WORK_W'(0));
      send_work(WORK_W'(1));
      send_work(WORK_W'(2));
      send_work(24'hFFFFFF);
      drain_results();
   endtask

   // More blocks than items stops the doubling with the remainder still too big.
   task automatic test_remainder_stuck();
      write_csr(wbp_pkg::CSR_NUM_PROCESSORS, CSR_DATA_W'(1));
      write_csr(wbp_pkg::CSR_MAX_BLOCK_SIZE, CSR_DATA_W'(2));
      send_work(WORK_W'(3));
      send_work(24'hFFFFFF);
      send_work(24'h800001);
      drain_results();
   endtask

   task automatic test_register_maximums();
      write_csr(wbp_pkg::CSR_NUM_PROCESSORS, '1);
      write_csr(wbp_pkg::CSR_MAX_BLOCK_SIZE, '1);
      send_work(WORK_W'(1));
      send_work(24'hFFFFFF);
      send_work(WORK_W'(2047 * 511));
      send_work(WORK_W'(2047 * 511 + 1));
      drain_results();
   endtask

   // Stall the response side long enough that the block backs up into the request side.
   task automatic test_receiver_holdoff();
      write_csr(wbp_pkg::CSR_NUM_PROCESSORS, CSR_DATA_W'(16));
      write_csr(wbp_pkg::CSR_MAX_BLOCK_SIZE, CSR_DATA_W'(256));
      send_idle_pct      = 0;
      rsp_holdoff_cycles = 400;
      repeat (8) send_work(WORK_W'($urandom_range(1, 4096)));
      drain_results();
   endtask

   task automatic test_sender_pause();
      send_idle_pct = 20;
      repeat (8) send_work(pick_work_count());
      drain_results();
      repeat (8) send_work(pick_work_count());
      drain_results();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 14; phase++) begin
         drain_results();
         write_csr(wbp_pkg::CSR_NUM_PROCESSORS, pick_num_processors(phase));
         write_csr(wbp_pkg::CSR_MAX_BLOCK_SIZE, pick_max_block(phase));
         // every fourth phase runs back to back on both sides
         send_idle_pct = (phase % 4 == 1) ? 0 : $urandom_range(10, 60);
         recv_idle_pct = (phase % 4 == 1) ? 0 : $urandom_range(10, 60);
         repeat (135) send_work(pick_work_count());
      end
      drain_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_registers();
      test_zero_registers();
      test_remainder_stuck();
      test_register_maximums();
      test_receiver_holdoff();
      test_sender_pause();
      test_random_traffic();
      recv_idle_pct = 30;
      drain_results();
      repeat (700) @(posedge clock);
      if (mismatch_count == 0)
         $display("work_block_partitioner regression: pass");
      else
         $display("work_block_partitioner regression: fail");
      $finish;
   end

   initial begin
      #80ms;
      $display("work_block_partitioner regression: fail");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/wbp_pkg.sv
src/wbp_divider.sv
src/work_block_partitioner.sv
bench/work_block_partitioner_tb.sv
